// File: rtl/sara_pkg.sv
// shared types and constants for the sonar range averager
package sara_pkg;

  localparam int unsigned PEND_W  = 30;
  localparam int unsigned SUM_W   = 46;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned PROD_W  = 54;
  localparam int unsigned RANGE_W = 38;

  localparam logic [PROD_W-1:0] RANGE_MAX = 54'd253999999746;

  localparam logic [7:0] CHAR_R    = 8'h52;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POLL = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] byte_value;
  } sara_in_t;

  typedef struct packed {
    logic [RANGE_W-1:0] range_tenth_mm;
    logic               no_reading;
  } sara_out_t;

  typedef struct packed {
    logic       byte_en;
    logic       clear;
    logic [7:0] byte_value;
  } parse_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: rtl/sonar_ascii_range_averager.sv
// top level of the sonar ascii range averager
//
// input channel (in_valid_i / in_ready_o / in_item_i) carries either a
// received serial byte or a poll. digits build a pending number, 'R' adds it
// to a running sum and count, other bytes are ignored. a byte item gives no
// result; the block is ready again on the next cycle.
// a poll gives one result on the output channel (out_valid_o / out_ready_i /
// out_item_o): floor(sum*254/count) in tenths of a millimetre, clamped to
// 253999999746, or no_reading with range 0 when the count is zero.
// a poll with readings goes from accept to the output register in steps:
// load the divider (the scaling by 254 is a shift and subtract on its
// input), divide at one quotient bit per cycle, clamp, then move into the
// output register; a poll with no readings goes to that move directly.
// in_ready_o is low while a poll is being worked on.
// the output register holds a result until taken; further bytes are still
// accepted meanwhile, and a new poll finishes only once the register is free.
// reset clears the pending number, sum, count and the output valid at once.
module sonar_ascii_range_averager #(
  parameter int unsigned DIGIT_BUFFER_CHARS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sara_pkg::sara_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sara_pkg::sara_out_t out_item_o
);
  import sara_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]        state_q, state_d;
  logic              in_acc, poll_acc;
  logic              out_valid_q, out_valid_d;
  sara_out_t         out_q;
  sara_out_t         res_q;
  logic [SUM_W-1:0]  sum_snap_q;
  logic [CNT_W-1:0]  cnt_snap_q;

  parse_ctrl_t       pctrl;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  count;

  logic              div_start;
  logic [PROD_W-1:0] product;
  div_stat_t         div_stat;
  logic [PROD_W-1:0] quotient;
  logic              emit_go;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign poll_acc   = in_acc && (in_item_i.operation == OP_POLL);

  always_comb begin
    pctrl.byte_en    = in_acc && (in_item_i.operation == OP_BYTE);
    pctrl.clear      = poll_acc;
    pctrl.byte_value = in_item_i.byte_value;
  end

  sara_parser #(
    .DIGIT_BUFFER_CHARS(DIGIT_BUFFER_CHARS)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (pctrl),
    .sum_o   (sum),
    .count_o (count)
  );

  // times 254 as (x << 8) - (x << 1)
  assign product   = {sum_snap_q, 8'd0} - {7'd0, sum_snap_q, 1'b0};
  assign div_start = (state_q == S_MUL);

  sara_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (cnt_snap_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  assign emit_go = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (poll_acc) begin
          state_d = (count == '0) ? S_EMIT : S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit_go) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll_acc) begin
      sum_snap_q <= sum;
      cnt_snap_q <= count;
      res_q.range_tenth_mm <= '0;
      res_q.no_reading     <= (count == '0);
    end else if (div_stat.done) begin
      res_q.range_tenth_mm <= (quotient > RANGE_MAX) ? RANGE_MAX[RANGE_W-1:0]
                                                     : quotient[RANGE_W-1:0];
      res_q.no_reading     <= 1'b0;
    end
    if (emit_go) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_poll_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    poll_acc |=> !in_ready_o)
    else $error("ready after poll item accepted");
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == S_DIV)
    else $error("divider finished outside its state");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.no_reading) |-> out_item_o.range_tenth_mm == '0)
    else $error("no reading flagged with nonzero range");
  a_start_from_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> div_stat.busy && state_q == S_DIV)
    else $error("divider not running after start");

endmodule

// File: rtl/sara_parser.sv
// ascii digit parser with saturating reading sum and count
module sara_parser #(
  parameter int unsigned DIGIT_BUFFER_CHARS = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sara_pkg::parse_ctrl_t       ctrl_i,
  output logic [sara_pkg::SUM_W-1:0]  sum_o,
  output logic [sara_pkg::CNT_W-1:0]  count_o
);
  import sara_pkg::*;

  localparam int unsigned DIG_W = $clog2(DIGIT_BUFFER_CHARS);
  localparam logic [DIG_W-1:0] DIG_LAST = DIG_W'(DIGIT_BUFFER_CHARS - 1);

  logic [PEND_W-1:0] pend_q, pend_d;
  logic [DIG_W-1:0]  digits_q, digits_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic              is_digit;
  logic [3:0]        digit_val;
  logic [PEND_W+3:0] pend_x10;
  logic [SUM_W:0]    sum_add;

  always_comb begin
    is_digit  = ctrl_i.byte_value inside {[CHAR_ZERO:CHAR_NINE]};
    digit_val = 4'(ctrl_i.byte_value - CHAR_ZERO);
    // times ten as two shifts and an add
    pend_x10  = {1'b0, pend_q, 3'b000} + {3'b000, pend_q, 1'b0} + {30'd0, digit_val};
    sum_add   = {1'b0, sum_q} + {{(SUM_W+1-PEND_W){1'b0}}, pend_q};

    pend_d   = pend_q;
    digits_d = digits_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;

    if (ctrl_i.clear) begin
      sum_d = '0;
      cnt_d = '0;
    end else if (ctrl_i.byte_en) begin
      if (ctrl_i.byte_value == CHAR_R) begin
        sum_d    = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        cnt_d    = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
        pend_d   = '0;
        digits_d = '0;
      end else if (is_digit) begin
        if (digits_q == DIG_LAST) begin
          // buffer would fill: drop the whole number
          pend_d   = '0;
          digits_d = '0;
        end else begin
          pend_d   = pend_x10[PEND_W-1:0];
          digits_d = digits_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      digits_q <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
    end else begin
      pend_q   <= pend_d;
      digits_q <= digits_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
    end
  end

  assign sum_o   = sum_q;
  assign count_o = cnt_q;

  a_digits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digits_q <= DIG_LAST)
    else $error("digit count beyond buffer");
  a_clear_wins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> (sum_q == '0 && cnt_q == '0))
    else $error("sum or count not cleared by poll");
  a_pend_on_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.clear && !ctrl_i.byte_en) |=> $stable(pend_q))
    else $error("pending value changed by poll");

endmodule

// File: rtl/sara_divider.sv
// restoring divider, one quotient bit per cycle
module sara_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sara_pkg::PROD_W-1:0]  dividend_i,
  input  logic [sara_pkg::CNT_W-1:0]   divisor_i,
  output sara_pkg::div_stat_t          stat_o,
  output logic [sara_pkg::PROD_W-1:0]  quotient_o
);
  import sara_pkg::*;

  localparam int unsigned STEP_W = $clog2(PROD_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PROD_W - 1);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  rem_q, dvs_q;
  logic [PROD_W-1:0] quo_q;

  logic [CNT_W:0] trial;
  logic [CNT_W:0] diff;
  logic           fits;

  always_comb begin
    trial = {rem_q, quo_q[PROD_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_LAST;
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath needs no reset
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_q <= {quo_q[PROD_W-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("done without a finished run");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !$past(start_i)) |-> rem_q < dvs_q)
    else $error("partial remainder not below divisor");

endmodule
